// ===== sv/keyboard_scancode_to_ascii_buffer_macros.svh =====
`ifndef KEYBOARD_SCANCODE_TO_ASCII_BUFFER_MACROS_SVH
`define KEYBOARD_SCANCODE_TO_ASCII_BUFFER_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define KSAB_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define KSAB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ksab_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ksab_pkg;

   // Request kinds carried on the input tuser.
   typedef enum logic {
      REQ_SCAN = 1'b0,
      REQ_POP  = 1'b1
   } req_kind_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Shift key make and break codes.
   localparam logic [7:0] LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] RSHIFT_BREAK = 8'hB6;

   localparam logic [7:0] LAST_KEY_CODE   = 8'd57;
   localparam logic [7:0] DIGIT_ROW_END   = 8'd14;
   localparam logic [6:0] CASE_OFFSET     = 7'd32;

   localparam logic [6:0] CH_ESC   = 7'h1B;
   localparam logic [6:0] CH_BS    = 7'h08;
   localparam logic [6:0] CH_ENTER = 7'h0A;

   // Unshifted character of each key; zero for keys with no character.
   function automatic logic [6:0] plain_char(input logic [7:0] code);
      logic [6:0] c;
      case (code)
         8'd1:  c = CH_ESC;
         8'd2:  c = 7'("1");
         8'd3:  c = 7'("2");
         8'd4:  c = 7'("3");
         8'd5:  c = 7'("4");
         8'd6:  c = 7'("5");
         8'd7:  c = 7'("6");
         8'd8:  c = 7'("7");
         8'd9:  c = 7'("8");
         8'd10: c = 7'("9");
         8'd11: c = 7'("0");
         8'd12: c = 7'("-");
         8'd13: c = 7'("=");
         8'd14: c = CH_BS;
         8'd16: c = 7'("q");
         8'd17: c = 7'("w");
         8'd18: c = 7'("e");
         8'd19: c = 7'("r");
         8'd20: c = 7'("t");
         8'd21: c = 7'("y");
         8'd22: c = 7'("u");
         8'd23: c = 7'("i");
         8'd24: c = 7'("o");
         8'd25: c = 7'("p");
         8'd26: c = 7'("[");
         8'd27: c = 7'("]");
         8'd28: c = CH_ENTER;
         8'd30: c = 7'("a");
         8'd31: c = 7'("s");
         8'd32: c = 7'("d");
         8'd33: c = 7'("f");
         8'd34: c = 7'("g");
         8'd35: c = 7'("h");
         8'd36: c = 7'("j");
         8'd37: c = 7'("k");
         8'd38: c = 7'("l");
         8'd39: c = 7'(";");
         8'd40: c = 7'h27;
         8'd41: c = 7'h60;
         8'd43: c = 7'h5C;
         8'd44: c = 7'("z");
         8'd45: c = 7'("x");
         8'd46: c = 7'("c");
         8'd47: c = 7'("v");
         8'd48: c = 7'("b");
         8'd49: c = 7'("n");
         8'd50: c = 7'("m");
         8'd51: c = 7'(",");
         8'd52: c = 7'(".");
         8'd53: c = 7'("/");
         8'd55: c = 7'("*");
         8'd57: c = 7'(" ");
         default: c = 7'd0;
      endcase
      return c;
   endfunction

   // Shifted symbols of the digit row.
   function automatic logic [6:0] digit_row_shifted(input logic [3:0] code);
      logic [6:0] c;
      case (code)
         4'd1:  c = CH_ESC;
         4'd2:  c = 7'("!");
         4'd3:  c = 7'("@");
         4'd4:  c = 7'("#");
         4'd5:  c = 7'("$");
         4'd6:  c = 7'("%");
         4'd7:  c = 7'("^");
         4'd8:  c = 7'("&");
         4'd9:  c = 7'("*");
         4'd10: c = 7'("(");
         4'd11: c = 7'(")");
         4'd12: c = 7'("_");
         4'd13: c = 7'("+");
         default: c = 7'd0;
      endcase
      return c;
   endfunction

   // Full translation of one scan code, with or without shift held.
   function automatic logic [6:0] translate_code(input logic [7:0] code,
                                                 input logic       shifted);
      logic [6:0] plain;
      logic [6:0] c;
      plain = plain_char(code);
      if (!shifted || code > LAST_KEY_CODE) begin
         c = plain;
      end else begin
         case (code)
            8'd26:   c = 7'("{");
            8'd27:   c = 7'("}");
            8'd39:   c = 7'(":");
            8'd40:   c = 7'h22;
            8'd41:   c = 7'("~");
            8'd43:   c = 7'("|");
            8'd51:   c = 7'("<");
            8'd52:   c = 7'(">");
            8'd53:   c = 7'("?");
            default: begin
               if (code < DIGIT_ROW_END) begin
                  c = digit_row_shifted(code[3:0]);
               end else if (plain >= 7'("a") && plain <= 7'("z")) begin
                  c = plain - CASE_OFFSET;
               end else begin
                  c = plain;
               end
            end
         endcase
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== sv/keyboard_scancode_to_ascii_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Translates scan code set 1 bytes to ASCII and keeps the characters on a
// last-in-first-out store of BUFFER_DEPTH entries. Each input transfer is
// either a scan byte (req_tuser low) or a pop of the newest character
// (req_tuser high), and produces exactly one result transfer. The block
// takes one transfer per clock while the result side does not stall it, and
// each input passes through an input register, then the translation table
// and stack update in front of the result register. The newest character
// sits in a register and the entries below it in a RAM with one write and
// one registered read port; the entry under the top is read ahead every
// cycle, which is what lets pops follow each other in consecutive cycles.
// The store needs no clearing after reset; the block is ready at once.
module keyboard_scancode_to_ascii_buffer #(
   parameter int BUFFER_DEPTH = 256
) (
   input  wire logic clock,
   input  wire logic reset,

   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] scan_byte
   input  wire logic       req_tuser,   // [0] req_type

   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // [6:0] char_code, [7] char_valid, [CW+7:8] stored_count,
   // [CW+9:CW+8] status, zero fill above
   output logic [((10 + $clog2(BUFFER_DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam int RW = ((10 + CW + 7) / 8) * 8;

   // Input register.
   logic       in_valid_ff;
   logic       in_type_ff;
   logic [7:0] in_byte_ff;

   // Result register.
   logic                   rsp_valid_ff;
   logic [6:0]             rsp_char_ff;
   logic                   rsp_cvalid_ff;
   logic [CW-1:0]          rsp_count_ff;
   ksab_pkg::status_type   rsp_status_ff;

   // Keyboard and stack state.
   logic          lshift_ff, lshift_in;
   logic          rshift_ff, rshift_in;
   logic [CW-1:0] count_ff, count_in;
   logic [6:0]    top_ff, top_in;

   // Item results.
   logic [6:0]           item_char;
   logic                 item_cvalid;
   ksab_pkg::status_type item_status;
   logic [6:0]           xlat_char;

   // Store port signals.
   logic          wr_en;
   logic [CW-1:0] rd_ptr;
   logic [6:0]    rd_data;

   logic advance;

   // The item in the input register moves on when the result slot is free.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_type_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   assign xlat_char = ksab_pkg::translate_code(in_byte_ff, lshift_ff | rshift_ff);

   // Per-item decode: shift tracking, translation, push and pop.
   always_comb begin
      lshift_in   = lshift_ff;
      rshift_in   = rshift_ff;
      count_in    = count_ff;
      top_in      = top_ff;
      item_char   = 7'd0;
      item_cvalid = 1'b0;
      item_status = ksab_pkg::STATUS_OK;
      wr_en       = 1'b0;
      if (advance) begin
         if (in_type_ff == ksab_pkg::REQ_POP) begin
            if (count_ff != '0) begin
               item_char   = top_ff;
               item_cvalid = 1'b1;
               count_in    = count_ff - CW'(1);
               top_in      = rd_data;
            end else begin
               item_status = ksab_pkg::STATUS_EMPTY;
            end
         end else if (in_byte_ff == ksab_pkg::LSHIFT_MAKE) begin
            lshift_in = 1'b1;
         end else if (in_byte_ff == ksab_pkg::LSHIFT_BREAK) begin
            lshift_in = 1'b0;
         end else if (in_byte_ff == ksab_pkg::RSHIFT_MAKE) begin
            rshift_in = 1'b1;
         end else if (in_byte_ff == ksab_pkg::RSHIFT_BREAK) begin
            rshift_in = 1'b0;
         end else if (xlat_char != 7'd0) begin
            item_char   = xlat_char;
            item_cvalid = 1'b1;
            if (count_ff < CW'(BUFFER_DEPTH)) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               top_in   = xlat_char;
            end else begin
               item_status = ksab_pkg::STATUS_FULL;
            end
         end
      end
   end

   // Read ahead the entry just below the next top of stack.
   assign rd_ptr = count_in - CW'(2);

   ksab_ram #(
      .WIDTH (7),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (xlat_char),
      .rd_addr (rd_ptr[AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lshift_ff <= 1'b0;
         rshift_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         lshift_ff <= lshift_in;
         rshift_ff <= rshift_in;
         count_ff  <= count_in;
      end
      top_ff <= top_in;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_char_ff   <= item_char;
         rsp_cvalid_ff <= item_cvalid;
         rsp_count_ff  <= count_in;
         rsp_status_ff <= item_status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RW'({rsp_status_ff, rsp_count_ff, rsp_cvalid_ff, rsp_char_ff});

endmodule

`default_nettype wire

// ===== sv/ksab_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module ksab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/ksab_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "keyboard_scancode_to_ascii_buffer_macros.svh"

// Port-level checks on the result stream.
module ksab_checker #(
   parameter int BUFFER_DEPTH = 256
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [((10 + $clog2(BUFFER_DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int CW = $clog2(BUFFER_DEPTH + 1);

   logic [6:0]    rsp_char;
   logic          rsp_cvalid;
   logic [CW-1:0] rsp_count;
   logic [1:0]    rsp_status;

   assign rsp_char   = rsp_tdata[6:0];
   assign rsp_cvalid = rsp_tdata[7];
   assign rsp_count  = rsp_tdata[CW+7:8];
   assign rsp_status = rsp_tdata[CW+9:CW+8];

   // A stalled result holds.
   `KSAB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // A dropped push only happens with the store full, and still reports its character.
   `KSAB_ASSERT_SAME(a_full_drop, rsp_tvalid && rsp_status == ksab_pkg::STATUS_FULL, rsp_cvalid && rsp_count == CW'(BUFFER_DEPTH), "full status with store not full")

   // A pop on an empty store returns nothing and leaves the count at zero.
   `KSAB_ASSERT_SAME(a_empty_pop, rsp_tvalid && rsp_status == ksab_pkg::STATUS_EMPTY, !rsp_cvalid && rsp_char == 7'd0 && rsp_count == '0, "bad empty pop result")

   // A reported character is never the null character, and the count stays bounded.
   `KSAB_ASSERT_SAME(a_char_count, rsp_tvalid, (!rsp_cvalid || rsp_char != 7'd0) && rsp_count <= CW'(BUFFER_DEPTH), "bad character or count")

endmodule

bind keyboard_scancode_to_ascii_buffer ksab_checker #(
   .BUFFER_DEPTH (BUFFER_DEPTH)
) u_ksab_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== tb/tb_keyboard_scancode_to_ascii_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_keyboard_scancode_to_ascii_buffer;

   localparam int DEPTH       = 256;
   localparam int RSP_W       = 24;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1500;

   // One result transfer, split into its fields.
   typedef struct packed {
      logic [6:0]           ch;
      logic                 valid;
      logic [8:0]           count;
      ksab_pkg::status_type status;
   } key_result_type;

   // One row of the directed table; exp is used only where typed is set.
   typedef struct {
      ksab_pkg::req_kind_type kind;
      logic [7:0]             code;
      bit                     typed;
      key_result_type         exp;
   } key_row_type;

   logic clock = 1'b0;
   logic reset;

   logic             req_tvalid;
   logic             req_tready;
   logic [7:0]       req_tdata;
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;

   // Translation tables and the shadow copy of the block's state.
   logic [6:0]  plain_key   [0:57];
   logic [6:0]  shifted_key [0:57];
   logic [6:0]  char_stack  [0:DEPTH-1];
   int          stack_depth;
   logic        shift_l;
   logic        shift_r;

   key_result_type pending_chars[$];
   key_row_type    directed_rows[$];

   bit calm;
   int errors = 0;
   int sent;
   int results = 0;
   int full_drops;
   int empty_pops;
   int peak_depth;
   int cycles = 0;

   keyboard_scancode_to_ascii_buffer #(
      .BUFFER_DEPTH(DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #10 clock = ~clock;

   // Writes a run of characters into one of the two key tables.
   task automatic load_row(input bit to_shifted, input int base, input string s);
      for (int i = 0; i < s.len(); i++) begin
         if (to_shifted) begin
            shifted_key[base + i] = 7'(s[i]);
         end else begin
            plain_key[base + i] = 7'(s[i]);
         end
      end
   endtask

   // Applies one request to the shadow state and returns the result it gives.
   function automatic key_result_type apply_keystroke(input ksab_pkg::req_kind_type kind,
                                                      input logic [7:0]             code);
      key_result_type r;
      logic [6:0]     ch;
      r.ch     = 7'd0;
      r.valid  = 1'b0;
      r.status = ksab_pkg::STATUS_OK;
      ch       = 7'd0;
      if (kind == ksab_pkg::REQ_POP) begin
         if (stack_depth > 0) begin
            stack_depth--;
            r.ch    = char_stack[stack_depth];
            r.valid = 1'b1;
         end else begin
            r.status = ksab_pkg::STATUS_EMPTY;
            empty_pops++;
         end
      end else if (code == ksab_pkg::LSHIFT_MAKE) begin
         shift_l = 1'b1;
      end else if (code == ksab_pkg::LSHIFT_BREAK) begin
         shift_l = 1'b0;
      end else if (code == ksab_pkg::RSHIFT_MAKE) begin
         shift_r = 1'b1;
      end else if (code == ksab_pkg::RSHIFT_BREAK) begin
         shift_r = 1'b0;
      end else begin
         if (code <= ksab_pkg::LAST_KEY_CODE) begin
            ch = (shift_l || shift_r) ? shifted_key[code] : plain_key[code];
         end
         if (ch != 7'd0) begin
            r.ch    = ch;
            r.valid = 1'b1;
            if (stack_depth < DEPTH) begin
               char_stack[stack_depth] = ch;
               stack_depth++;
            end else begin
               r.status = ksab_pkg::STATUS_FULL;
               full_drops++;
            end
         end
      end
      if (stack_depth > peak_depth) begin
         peak_depth = stack_depth;
      end
      r.count = 9'(stack_depth);
      return r;
   endfunction

   function automatic void add_row(input ksab_pkg::req_kind_type kind,
                                   input logic [7:0] code,
                                   input bit typed, input logic [6:0] ch,
                                   input logic valid, input logic [8:0] count,
                                   input ksab_pkg::status_type status);
      key_row_type row;
      row.kind       = kind;
      row.code       = code;
      row.typed      = typed;
      row.exp.ch     = ch;
      row.exp.valid  = valid;
      row.exp.count  = count;
      row.exp.status = status;
      directed_rows.push_back(row);
   endfunction

   // Offers one input transfer, with random gaps ahead of it, and records
   // the expected result once the block has taken it.
   task automatic send_item(input ksab_pkg::req_kind_type kind, input logic [7:0] code,
                            input bit typed, input key_result_type typed_exp);
      key_result_type predicted;
      while (!calm && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= code;
      do @(posedge clock); while (!req_tready);
      predicted = apply_keystroke(kind, code);
      pending_chars.push_back(typed ? typed_exp : predicted);
      sent++;
   endtask

   // Result side: random back-pressure and field-by-field comparison.
   always @(posedge clock) begin : result_check
      key_result_type exp;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 16);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         results++;
         if (pending_chars.size() == 0) begin
            $error("result transfer with no expected result waiting");
            errors++;
         end else begin
            exp = pending_chars.pop_front();
            if (rsp_tdata[6:0] != exp.ch) begin
               $error("char_code: expected %h, got %h", exp.ch, rsp_tdata[6:0]);
               errors++;
            end
            if (rsp_tdata[7] != exp.valid) begin
               $error("char_valid: expected %0d, got %0d", exp.valid, rsp_tdata[7]);
               errors++;
            end
            if (rsp_tdata[16:8] != exp.count) begin
               $error("stored_count: expected %0d, got %0d", exp.count, rsp_tdata[16:8]);
               errors++;
            end
            if (rsp_tdata[18:17] != exp.status) begin
               $error("status: expected %0d, got %0d", exp.status, rsp_tdata[18:17]);
               errors++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Run timed out after %0d cycles.", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      ksab_pkg::req_kind_type kind;
      logic [7:0]             code;
      int                     seg;
      int                     seg_len;
      int                     pick;
      int                     random_sent;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'd0;
      req_tuser  <= ksab_pkg::REQ_SCAN;
      calm        = 1'b0;
      sent        = 0;
      full_drops  = 0;
      empty_pops  = 0;
      peak_depth  = 0;
      stack_depth = 0;
      shift_l     = 1'b0;
      shift_r     = 1'b0;

      // Unshifted key map.
      for (int i = 0; i <= 57; i++) begin
         plain_key[i] = 7'd0;
      end
      plain_key[1]  = ksab_pkg::CH_ESC;
      load_row(1'b0, 2, "1234567890-=");
      plain_key[14] = ksab_pkg::CH_BS;
      load_row(1'b0, 16, "qwertyuiop[]");
      plain_key[28] = ksab_pkg::CH_ENTER;
      load_row(1'b0, 30, "asdfghjkl;");
      plain_key[40] = 7'h27;
      plain_key[41] = 7'h60;
      plain_key[43] = 7'h5C;
      load_row(1'b0, 44, "zxcvbnm,./");
      plain_key[55] = 7'h2A;
      plain_key[57] = 7'h20;

      // Shifted map: letters go to upper case, then the shifted symbols.
      for (int i = 0; i <= 57; i++) begin
         if (plain_key[i] >= 7'h61 && plain_key[i] <= 7'h7A) begin
            shifted_key[i] = plain_key[i] - 7'd32;
         end else begin
            shifted_key[i] = plain_key[i];
         end
      end
      load_row(1'b1, 2, "!@#$%^&*()_+");
      load_row(1'b1, 26, "{}");
      load_row(1'b1, 39, ":");
      shifted_key[40] = 7'h22;
      load_row(1'b1, 41, "~");
      load_row(1'b1, 43, "|");
      load_row(1'b1, 51, "<>?");

      // Directed rows: empty pop, control characters, keys with no character,
      // shifted keys with and without a shifted form, then pops.
      add_row(ksab_pkg::REQ_POP,  8'h00, 1'b1, 7'h00, 1'b0, 9'd0,
              ksab_pkg::STATUS_EMPTY);
      add_row(ksab_pkg::REQ_SCAN, 8'h01, 1'b1, ksab_pkg::CH_ESC, 1'b1, 9'd1,
              ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h0E, 1'b1, ksab_pkg::CH_BS, 1'b1, 9'd2,
              ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h1C, 1'b1, ksab_pkg::CH_ENTER, 1'b1, 9'd3,
              ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h00, 1'b1, 7'h00, 1'b0, 9'd3, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h3A, 1'b1, 7'h00, 1'b0, 9'd3, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'hFF, 1'b1, 7'h00, 1'b0, 9'd3, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h0F, 1'b1, 7'h00, 1'b0, 9'd3, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h9E, 1'b1, 7'h00, 1'b0, 9'd3, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h39, 1'b0, 7'h00, 1'b0, 9'd0, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, ksab_pkg::LSHIFT_MAKE, 1'b1, 7'h00, 1'b0, 9'd4,
              ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h02, 1'b0, 7'h00, 1'b0, 9'd0, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h1E, 1'b0, 7'h00, 1'b0, 9'd0, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h27, 1'b0, 7'h00, 1'b0, 9'd0, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h39, 1'b0, 7'h00, 1'b0, 9'd0, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h01, 1'b0, 7'h00, 1'b0, 9'd0, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, ksab_pkg::LSHIFT_BREAK, 1'b0, 7'h00, 1'b0, 9'd0,
              ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, ksab_pkg::RSHIFT_MAKE, 1'b0, 7'h00, 1'b0, 9'd0,
              ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h37, 1'b0, 7'h00, 1'b0, 9'd0, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h1C, 1'b0, 7'h00, 1'b0, 9'd0, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h0D, 1'b0, 7'h00, 1'b0, 9'd0, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, ksab_pkg::RSHIFT_BREAK, 1'b0, 7'h00, 1'b0, 9'd0,
              ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_SCAN, 8'h10, 1'b0, 7'h00, 1'b0, 9'd0, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_POP,  8'hA5, 1'b0, 7'h00, 1'b0, 9'd0, ksab_pkg::STATUS_OK);
      add_row(ksab_pkg::REQ_POP,  8'h5A, 1'b0, 7'h00, 1'b0, 9'd0, ksab_pkg::STATUS_OK);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].kind, directed_rows[i].code,
                   directed_rows[i].typed, directed_rows[i].exp);
      end

      // Random part in segments: a fill past full and a drain past empty
      // first, then a mix of typing, bursts and raw noise.
      random_sent = 0;
      seg         = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (seg == 0) begin
            pick = 0;
         end else if (seg == 1) begin
            pick = 2;
         end else begin
            pick = $urandom_range(9);
         end
         seg++;
         if (pick <= 1) begin
            seg_len = $urandom_range(320, 280);
         end else if (pick == 2) begin
            seg_len = $urandom_range(300, 260);
         end else if (pick == 3) begin
            seg_len = 20;
         end else begin
            seg_len = $urandom_range(60, 30);
         end
         for (int n = 0; n < seg_len && random_sent < RANDOM_ITEMS; n++) begin
            calm = (random_sent >= 700 && random_sent < 1000);
            if (pick <= 1) begin
               // Burst of key presses with no pops.
               kind = ksab_pkg::REQ_SCAN;
               code = 8'($urandom_range(57));
            end else if (pick == 2) begin
               // Burst of pops; the byte is ignored but still random.
               kind = ksab_pkg::REQ_POP;
               code = 8'($urandom_range(255));
            end else if (pick == 3) begin
               kind = ksab_pkg::req_kind_type'($urandom_range(1));
               code = 8'($urandom_range(255));
            end else begin
               // Ordinary typing: key presses, releases, shift and pops.
               kind = ksab_pkg::REQ_SCAN;
               code = 8'($urandom_range(57));
               case ($urandom_range(9))
                  0, 1: begin
                     kind = ksab_pkg::REQ_POP;
                     code = 8'($urandom_range(255));
                  end
                  2: begin
                     if ($urandom_range(1)) begin
                        code = shift_l ? ksab_pkg::LSHIFT_BREAK : ksab_pkg::LSHIFT_MAKE;
                     end else begin
                        code = shift_r ? ksab_pkg::RSHIFT_BREAK : ksab_pkg::RSHIFT_MAKE;
                     end
                  end
                  3: code = code | 8'h80;
                  default: ;
               endcase
            end
            send_item(kind, code, 1'b0, '0);
            random_sent++;
         end
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;

      while (pending_chars.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d requests (scan bytes and pops), %0d results checked.",
               sent, results);
      $display("Buffer peaked at %0d, %0d pushes dropped when full, %0d pops on empty.",
               peak_depth, full_drops, empty_pops);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
